// ===== sv/blk3_pkg.sv =====
`timescale 1ns / 1ps
package blk3_pkg;

   localparam int STACK_DEPTH_DEF = 54;

   localparam logic [31:0] FLAG_CHUNK_START = 32'd1;
   localparam logic [31:0] FLAG_CHUNK_END   = 32'd2;
   localparam logic [31:0] FLAG_PARENT      = 32'd4;
   localparam logic [31:0] FLAG_ROOT        = 32'd8;

   localparam logic [7:0][31:0] BLAKE_IV = {
      32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
      32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
   };

   typedef struct packed {
      logic [31:0] msg_word;
      logic [2:0]  byte_count;
      logic        end_of_message;
   } req_data_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        last_word;
   } rsp_data_type;

   typedef struct packed {
      logic latch;
      logic insert;
      logic start_blk;
      logic start_par;
      logic use_fill;
      logic chunk_fin;
      logic root;
      logic store_cv;
      logic store_right;
      logic load_tot;
      logic pop;
      logic push_fin;
      logic store_dig;
      logic msg_reset;
      logic out_next;
   } blk3_cmd_type;

   typedef struct packed {
      logic rem_zero;
      logic fill_full;
      logic last_block;
      logic eom;
      logic done;
      logic stack_empty;
      logic tot_odd;
      logic out_last;
   } blk3_stat_type;

   function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] n);
      return (v >> n) | (v << (6'd32 - {1'b0, n}));
   endfunction

   function automatic logic [15:0][31:0] msg_perm(input logic [15:0][31:0] m);
      logic [15:0][31:0] t;
      t[0]  = m[2];  t[1]  = m[6];  t[2]  = m[3];  t[3]  = m[10];
      t[4]  = m[7];  t[5]  = m[0];  t[6]  = m[4];  t[7]  = m[13];
      t[8]  = m[1];  t[9]  = m[11]; t[10] = m[12]; t[11] = m[5];
      t[12] = m[9];  t[13] = m[14]; t[14] = m[15]; t[15] = m[8];
      return t;
   endfunction

endpackage

// ===== sv/blk3_ram.sv =====
`timescale 1ns / 1ps
module blk3_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== sv/blk3_dp.sv =====
`timescale 1ns / 1ps
module blk3_dp import blk3_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  blk3_cmd_type  cmd,
   output blk3_stat_type stat,
   input  req_data_type  req_data,
   output rsp_data_type  rsp_data
);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [7:0][31:0]  cv_ff;
   logic [511:0]      buf_ff, buf_in;
   logic [6:0]        fill_ff;
   logic [4:0]        bd_ff;
   logic [63:0]       chunk_ff;
   logic [CW-1:0]     sc_ff;
   logic [63:0]       tot_ff;
   logic [7:0][31:0]  right_ff;
   logic [7:0][31:0]  dig_ff;
   logic [2:0]        oidx_ff;
   logic [31:0]       word_ff;
   logic [2:0]        rem_ff;
   logic              eom_ff;
   logic [15:0][31:0] v_ff, v_in;
   logic [15:0][31:0] m_ff;
   logic [4:0]        step_ff;
   logic              run_ff;
   logic              done_ff;

   logic [6:0]        room;
   logic [2:0]        k;
   logic [2:0]        nsat;
   logic [7:0][31:0]  comp_out;
   logic [255:0]      ram_rdata;
   logic [AW-1:0]     pop_addr;
   logic              do_push;
   logic [31:0]       start_flag;
   logic [15:0][31:0] init_v;

   blk3_ram #(.WIDTH(256), .DEPTH(STACK_DEPTH)) u_stack (
      .clock (clock),
      .we    (do_push),
      .waddr (sc_ff[AW-1:0]),
      .wdata (right_ff),
      .re    (cmd.pop),
      .raddr (pop_addr),
      .rdata (ram_rdata)
   );

   assign pop_addr = AW'(sc_ff - CW'(1));
   assign do_push  = cmd.push_fin && (sc_ff < CW'(STACK_DEPTH));
   assign nsat     = (req_data.byte_count > 3'd4) ? 3'd4 : req_data.byte_count;

   // byte insertion
   always_comb begin
      logic [5:0] pos;
      room   = 7'd64 - fill_ff;
      k      = ({4'b0, rem_ff} < room) ? rem_ff : room[2:0];
      buf_in = buf_ff;
      for (int j = 0; j < 4; j++) begin
         pos = fill_ff[5:0] + 6'(j);
         if (3'(j) < k) begin
            buf_in[{pos, 3'b000} +: 8] = word_ff[j*8 +: 8];
         end
      end
   end

   // compression setup
   always_comb begin
      start_flag = (bd_ff == 5'd0) ? FLAG_CHUNK_START : 32'd0;
      init_v[11:8] = BLAKE_IV[3:0];
      if (cmd.start_par) begin
         init_v[7:0] = BLAKE_IV;
         init_v[12]  = 32'd0;
         init_v[13]  = 32'd0;
         init_v[14]  = 32'd64;
         init_v[15]  = FLAG_PARENT | (cmd.root ? FLAG_ROOT : 32'd0);
      end else begin
         init_v[7:0] = cv_ff;
         init_v[12]  = chunk_ff[31:0];
         init_v[13]  = chunk_ff[63:32];
         init_v[14]  = cmd.use_fill ? {25'd0, fill_ff} : 32'd64;
         init_v[15]  = start_flag | (cmd.chunk_fin ? FLAG_CHUNK_END : 32'd0)
                     | (cmd.root ? FLAG_ROOT : 32'd0);
      end
   end

   // half of four g functions per cycle
   always_comb begin
      logic [31:0] a, b, c, d, x;
      logic [4:0]  r1, r2;
      int ia, ib, ic, id;
      v_in = v_ff;
      for (int i = 0; i < 4; i++) begin
         ia = i;
         ib = 4 + ((i + (step_ff[1] ? 1 : 0)) & 3);
         ic = 8 + ((i + (step_ff[1] ? 2 : 0)) & 3);
         id = 12 + ((i + (step_ff[1] ? 3 : 0)) & 3);
         x  = m_ff[(step_ff[1] ? 8 : 0) + 2*i + (step_ff[0] ? 1 : 0)];
         r1 = step_ff[0] ? 5'd8 : 5'd16;
         r2 = step_ff[0] ? 5'd7 : 5'd12;
         a  = v_ff[ia] + v_ff[ib] + x;
         d  = rotr32(v_ff[id] ^ a, r1);
         c  = v_ff[ic] + d;
         b  = rotr32(v_ff[ib] ^ c, r2);
         v_in[ia] = a;
         v_in[ib] = b;
         v_in[ic] = c;
         v_in[id] = d;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         comp_out[i] = v_ff[i] ^ v_ff[i+8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff    <= BLAKE_IV;
         buf_ff   <= '0;
         fill_ff  <= '0;
         bd_ff    <= '0;
         chunk_ff <= '0;
         sc_ff    <= '0;
         oidx_ff  <= '0;
         rem_ff   <= '0;
         eom_ff   <= 1'b0;
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         done_ff <= run_ff && !(cmd.start_blk || cmd.start_par) && (step_ff == 5'd27);
         if (cmd.latch) begin
            word_ff <= req_data.msg_word;
            rem_ff  <= nsat;
            eom_ff  <= req_data.end_of_message;
         end
         if (cmd.insert) begin
            buf_ff  <= buf_in;
            fill_ff <= fill_ff + {4'd0, k};
            rem_ff  <= rem_ff - k;
            word_ff <= word_ff >> {k, 3'b000};
         end
         if (cmd.start_blk || cmd.start_par) begin
            v_ff    <= init_v;
            m_ff    <= cmd.start_par ? {right_ff, ram_rdata} : buf_ff;
            step_ff <= '0;
            run_ff  <= 1'b1;
         end else if (run_ff) begin
            v_ff    <= v_in;
            step_ff <= step_ff + 5'd1;
            if (step_ff[1:0] == 2'd3) begin
               m_ff <= msg_perm(m_ff);
            end
            if (step_ff == 5'd27) begin
               run_ff <= 1'b0;
            end
         end
         if (cmd.store_cv) begin
            cv_ff   <= comp_out;
            bd_ff   <= bd_ff + 5'd1;
            buf_ff  <= '0;
            fill_ff <= '0;
         end
         if (cmd.store_right) begin
            right_ff <= comp_out;
         end
         if (cmd.load_tot) begin
            tot_ff <= chunk_ff + 64'd1;
         end
         if (cmd.pop) begin
            sc_ff  <= sc_ff - CW'(1);
            tot_ff <= tot_ff >> 1;
         end
         if (cmd.push_fin) begin
            if (do_push) begin
               sc_ff <= sc_ff + CW'(1);
            end
            chunk_ff <= chunk_ff + 64'd1;
            cv_ff    <= BLAKE_IV;
            bd_ff    <= '0;
            buf_ff   <= '0;
            fill_ff  <= '0;
         end
         if (cmd.store_dig) begin
            dig_ff <= comp_out;
         end
         if (cmd.msg_reset) begin
            cv_ff    <= BLAKE_IV;
            buf_ff   <= '0;
            fill_ff  <= '0;
            bd_ff    <= '0;
            chunk_ff <= '0;
            sc_ff    <= '0;
            oidx_ff  <= '0;
         end
         if (cmd.out_next) begin
            oidx_ff <= oidx_ff + 3'd1;
         end
      end
   end

   assign stat.rem_zero    = (rem_ff == 3'd0);
   assign stat.fill_full   = (fill_ff == 7'd64);
   assign stat.last_block  = (bd_ff >= 5'd15);
   assign stat.eom         = eom_ff;
   assign stat.done        = done_ff;
   assign stat.stack_empty = (sc_ff == '0);
   assign stat.tot_odd     = tot_ff[0];
   assign stat.out_last    = (oidx_ff == 3'd7);

   assign rsp_data.digest_word = dig_ff[oidx_ff];
   assign rsp_data.last_word   = (oidx_ff == 3'd7);
endmodule

// ===== sv/blk3_ctrl.sv =====
`timescale 1ns / 1ps
module blk3_ctrl import blk3_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  blk3_stat_type stat,
   output blk3_cmd_type  cmd
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ABSORB = 4'd1;
   localparam logic [3:0] S_BRUN   = 4'd2;
   localparam logic [3:0] S_CRUN   = 4'd3;
   localparam logic [3:0] S_MCHK   = 4'd4;
   localparam logic [3:0] S_MRD    = 4'd5;
   localparam logic [3:0] S_MRUN   = 4'd6;
   localparam logic [3:0] S_FBLK   = 4'd7;
   localparam logic [3:0] S_FRUN   = 4'd8;
   localparam logic [3:0] S_FRD    = 4'd9;
   localparam logic [3:0] S_OUT    = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_ABSORB;
            end
         end
         S_ABSORB: begin
            if (stat.rem_zero) begin
               state_in = stat.eom ? S_FBLK : S_IDLE;
            end else if (stat.fill_full) begin
               cmd.start_blk = 1'b1;
               if (stat.last_block) begin
                  cmd.chunk_fin = 1'b1;
                  state_in      = S_CRUN;
               end else begin
                  state_in = S_BRUN;
               end
            end else begin
               cmd.insert = 1'b1;
            end
         end
         S_BRUN: begin
            if (stat.done) begin
               cmd.store_cv = 1'b1;
               state_in     = S_ABSORB;
            end
         end
         S_CRUN: begin
            if (stat.done) begin
               cmd.store_right = 1'b1;
               cmd.load_tot    = 1'b1;
               state_in        = S_MCHK;
            end
         end
         S_MCHK: begin
            if (!stat.tot_odd && !stat.stack_empty) begin
               cmd.pop  = 1'b1;
               state_in = S_MRD;
            end else begin
               cmd.push_fin = 1'b1;
               state_in     = S_ABSORB;
            end
         end
         S_MRD: begin
            cmd.start_par = 1'b1;
            state_in      = S_MRUN;
         end
         S_MRUN: begin
            if (stat.done) begin
               cmd.store_right = 1'b1;
               state_in        = S_MCHK;
            end
         end
         S_FBLK: begin
            cmd.start_blk = 1'b1;
            cmd.use_fill  = 1'b1;
            cmd.chunk_fin = 1'b1;
            cmd.root      = stat.stack_empty;
            state_in      = S_FRUN;
         end
         S_FRUN: begin
            if (stat.done) begin
               if (stat.stack_empty) begin
                  cmd.store_dig = 1'b1;
                  cmd.msg_reset = 1'b1;
                  state_in      = S_OUT;
               end else begin
                  cmd.store_right = 1'b1;
                  cmd.pop         = 1'b1;
                  state_in        = S_FRD;
               end
            end
         end
         S_FRD: begin
            cmd.start_par = 1'b1;
            cmd.root      = stat.stack_empty;
            state_in      = S_FRUN;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               cmd.out_next = 1'b1;
               if (stat.out_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
endmodule

// ===== sv/blake3_stream_hasher_top.sv =====
`timescale 1ns / 1ps
// unkeyed blake3-256 hasher over a byte stream
// req channel: one transaction carries a little-endian message word, its byte
//   count (0..4, values above 4 count as 4) and an end-of-message mark
// rsp channel: eight transactions per message, digest word 0 first,
//   last_word set on word 7
// per word: a word without a block boundary is accepted, inserted and checked;
//   a word that starts a new block adds one compression, run as one g-function
//   half per lane per cycle in the shared round unit
// a chunk end adds a merge check, and each merge a stack read and a parent
//   compression
// after the final word: it is absorbed, then each compression of the root path
//   runs in turn; after the root compression the first digest word follows next cycle
//   and the digest is held until all eight words are taken
// req_stall is high while a word is absorbed, compressed or the digest drains
// rsp_stall holds the current digest word; no new message word is taken then
// after the eighth word the hasher is ready for the next message
// reset (synchronous) clears all message state and drops any pending digest
module blake3_stream_hasher_top import blk3_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data
);
   blk3_cmd_type  cmd;
   blk3_stat_type stat;

   blk3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   blk3_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );
endmodule

// ===== test/tb_blake3_stream_hasher_top.sv =====
`timescale 1ns / 1ps
module tb_blake3_stream_hasher_top;
   import blk3_pkg::*;

   localparam int HASH_STACK = 54;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [31:0] F_START = 32'd1;
   localparam logic [31:0] F_END = 32'd2;
   localparam logic [31:0] F_PARENT = 32'd4;
   localparam logic [31:0] F_ROOT = 32'd8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_data_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_data_type rsp_data;

   blake3_stream_hasher_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hash state of the predictor
   logic [7:0][31:0] cv_words;
   logic [15:0][31:0] blk_words;
   int unsigned blk_fill;
   int unsigned blks_done;
   logic [63:0] chunk_ctr;
   logic [7:0][31:0] subtrees [HASH_STACK];
   int unsigned subtree_count;

   req_data_type word_queue[$];
   rsp_data_type digest_queue[$];
   int errors = 0;
   bit idle_free = 1'b0;
   bit hold_send = 1'b0;
   bit req_taken = 1'b0;
   int quiet_cycles = 0;

   function automatic logic [31:0] ror32(logic [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function automatic logic [7:0][31:0] compress(logic [7:0][31:0] h,
         logic [15:0][31:0] m, logic [63:0] ctr, logic [31:0] len, logic [31:0] flg);
      logic [15:0][31:0] v;
      logic [15:0][31:0] t;
      logic [7:0][31:0] o;
      int lane_a[8] = '{0, 1, 2, 3, 0, 1, 2, 3};
      int lane_b[8] = '{4, 5, 6, 7, 5, 6, 7, 4};
      int lane_c[8] = '{8, 9, 10, 11, 10, 11, 8, 9};
      int lane_d[8] = '{12, 13, 14, 15, 15, 12, 13, 14};
      int perm[16] = '{2, 6, 3, 10, 7, 0, 4, 13, 1, 11, 12, 5, 9, 14, 15, 8};
      int a, b, c, d;
      for (int i = 0; i < 8; i++) v[i] = h[i];
      for (int i = 0; i < 4; i++) v[8 + i] = BLAKE_IV[i];
      v[12] = ctr[31:0];
      v[13] = ctr[63:32];
      v[14] = len;
      v[15] = flg;
      for (int r = 0; r < 7; r++) begin
         for (int g = 0; g < 8; g++) begin
            a = lane_a[g]; b = lane_b[g]; c = lane_c[g]; d = lane_d[g];
            v[a] = v[a] + v[b] + m[2 * g];
            v[d] = ror32(v[d] ^ v[a], 16);
            v[c] = v[c] + v[d];
            v[b] = ror32(v[b] ^ v[c], 12);
            v[a] = v[a] + v[b] + m[2 * g + 1];
            v[d] = ror32(v[d] ^ v[a], 8);
            v[c] = v[c] + v[d];
            v[b] = ror32(v[b] ^ v[c], 7);
         end
         for (int i = 0; i < 16; i++) t[i] = m[perm[i]];
         m = t;
      end
      for (int i = 0; i < 8; i++) o[i] = v[i] ^ v[i + 8];
      return o;
   endfunction

   function automatic logic [31:0] chunk_flag();
      return (blks_done == 0) ? F_START : 32'd0;
   endfunction

   task automatic hash_clear();
      cv_words = BLAKE_IV;
      blk_words = '0;
      blk_fill = 0;
      blks_done = 0;
      chunk_ctr = '0;
      subtree_count = 0;
   endtask

   task automatic close_chunk();
      logic [7:0][31:0] cv;
      logic [63:0] total;
      logic [15:0][31:0] m;
      cv = compress(cv_words, blk_words, chunk_ctr, 32'd64, chunk_flag() | F_END);
      total = chunk_ctr + 64'd1;
      while (total[0] == 1'b0 && subtree_count > 0) begin
         subtree_count--;
         m = {cv, subtrees[subtree_count]};
         cv = compress(BLAKE_IV, m, 64'd0, 32'd64, F_PARENT);
         total = total >> 1;
      end
      if (subtree_count < HASH_STACK) begin
         subtrees[subtree_count] = cv;
         subtree_count++;
      end
      chunk_ctr = chunk_ctr + 64'd1;
      cv_words = BLAKE_IV;
      blks_done = 0;
      blk_words = '0;
      blk_fill = 0;
   endtask

   task automatic take_byte(logic [7:0] b);
      if (blk_fill >= 64) begin
         if (blks_done >= 15) close_chunk();
         else begin
            cv_words = compress(cv_words, blk_words, chunk_ctr, 32'd64, chunk_flag());
            blks_done++;
            blk_words = '0;
            blk_fill = 0;
         end
      end
      blk_words[blk_fill >> 2][(blk_fill & 3) * 8 +: 8] = b;
      blk_fill++;
   endtask

   task automatic predict_word(req_data_type w);
      int n;
      logic [7:0][31:0] h;
      logic [7:0][31:0] right;
      logic [15:0][31:0] m;
      logic [63:0] ctr;
      logic [31:0] len;
      logic [31:0] flg;
      rsp_data_type r;
      n = (w.byte_count > 3'd4) ? 4 : int'(w.byte_count);
      for (int i = 0; i < n; i++) take_byte(w.msg_word[8 * i +: 8]);
      if (w.end_of_message) begin
         h = cv_words;
         m = blk_words;
         ctr = chunk_ctr;
         len = blk_fill;
         flg = chunk_flag() | F_END;
         while (subtree_count > 0) begin
            right = compress(h, m, ctr, len, flg);
            subtree_count--;
            m = {right, subtrees[subtree_count]};
            h = BLAKE_IV;
            ctr = '0;
            len = 32'd64;
            flg = F_PARENT;
         end
         h = compress(h, m, 64'd0, len, flg | F_ROOT);
         for (int i = 0; i < 8; i++) begin
            r.digest_word = h[i];
            r.last_word = (i == 7);
            digest_queue.push_back(r);
         end
         hash_clear();
      end
   endtask

   task automatic add_message(int nbytes, int tail_cnt);
      req_data_type w;
      int left;
      left = nbytes;
      while (left > 0) begin
         w.msg_word = $urandom;
         w.byte_count = (left >= 4) ? 3'd4 : left[2:0];
         w.end_of_message = 1'b0;
         left -= 4;
         if (left <= 0 && tail_cnt < 0) w.end_of_message = 1'b1;
         word_queue.push_back(w);
      end
      if (nbytes == 0 || tail_cnt >= 0) begin
         w.msg_word = $urandom;
         w.byte_count = (tail_cnt < 0) ? 3'd0 : tail_cnt[2:0];
         w.end_of_message = 1'b1;
         word_queue.push_back(w);
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (word_queue.size() > 0 && !hold_send
                  && (idle_free || $urandom_range(99) >= 36)) begin
               req_valid <= 1'b1;
               req_data <= word_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= !idle_free && $urandom_range(99) < 36;
      end
   end

   // monitor
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) predict_word(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (digest_queue.size() == 0) begin
               $display("%0t unexpected digest word: actual %h/%b", $realtime,
                  rsp_data.digest_word, rsp_data.last_word);
               errors++;
            end else begin
               if (rsp_data.digest_word !== digest_queue[0].digest_word) begin
                  $display("%0t digest_word mismatch: expected %h actual %h", $realtime,
                     digest_queue[0].digest_word, rsp_data.digest_word);
                  errors++;
               end
               if (rsp_data.last_word !== digest_queue[0].last_word) begin
                  $display("%0t last_word mismatch: expected %b actual %b", $realtime,
                     digest_queue[0].last_word, rsp_data.last_word);
                  errors++;
               end
               void'(digest_queue.pop_front());
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      req_data_type w;
      int sizes[4] = '{0, 1, 65, 2049};
      hash_clear();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // directed: empty message, edge widths, odd byte counts
      add_message(0, -1);
      w.msg_word = 32'hFFFF_FFFF; w.byte_count = 3'd7; w.end_of_message = 1'b1;
      word_queue.push_back(w);
      w.msg_word = 32'h0000_0000; w.byte_count = 3'd5; w.end_of_message = 1'b0;
      word_queue.push_back(w);
      w.msg_word = 32'hA5A5_5A5A; w.byte_count = 3'd2; w.end_of_message = 1'b0;
      word_queue.push_back(w);
      w.msg_word = 32'h1234_5678; w.byte_count = 3'd6; w.end_of_message = 1'b0;
      word_queue.push_back(w);
      w.msg_word = 32'h8765_4321; w.byte_count = 3'd3; w.end_of_message = 1'b1;
      word_queue.push_back(w);
      add_message(3, 1);
      wait (word_queue.size() == 0);
      // sender holds off until all digests are back
      hold_send = 1'b1;
      @(posedge clock);
      wait (!req_valid);
      wait (digest_queue.size() == 0);
      hold_send = 1'b0;
      // chunk and block boundaries, with no idling
      idle_free = 1'b1;
      for (int i = 0; i < 4; i++) add_message(sizes[i], -1);
      wait (word_queue.size() == 0);
      idle_free = 1'b0;
      // random short messages
      for (int k = 0; k < 6; k++) begin
         if ($urandom_range(3) == 0)
            add_message($urandom_range(40, 0), $urandom_range(7, 0));
         else add_message($urandom_range(40, 0), -1);
         if ($urandom_range(4) == 0) begin
            w.msg_word = $urandom; w.byte_count = $urandom_range(7, 0);
            w.end_of_message = 1'b0;
            word_queue.push_back(w);
         end
         wait (word_queue.size() < 20);
      end
      wait (word_queue.size() == 0);
      @(posedge clock);
      wait (!req_valid);
      wait (digest_queue.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && digest_queue.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

// ===== files.f =====
sv/blk3_pkg.sv
sv/blk3_ram.sv
sv/blk3_dp.sv
sv/blk3_ctrl.sv
sv/blake3_stream_hasher_top.sv
test/tb_blake3_stream_hasher_top.sv
